### design/mi3_pkg.sv
// Shared definitions for the 3x3 matrix inverse core.
// Holds default widths and the sign/overflow control word handed to each divider lane.
`default_nettype none

package mi3_pkg;

    // Default fixed-point format: Q16.16
    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    // Width of the determinant floor register
    localparam int MIN_DET_BITS = 31;

    // Control that travels with one quotient through its divider lane
    typedef struct packed {
        logic neg;   // result is negative
        logic ovf;   // quotient known to exceed any representable value
    } mi3_sgn_t;

endpackage

`default_nettype wire

### design/mi3_div_lane.sv
// One pipelined restoring divider lane for the 3x3 matrix inverse core.
// Depends on mi3_pkg; produces a signed, saturated quotient one bit per stage.
`default_nettype none

module mi3_div_lane #(
    parameter int W    = 32,
    parameter int NUMW = 100,
    parameter int DENW = 97,
    parameter int NW   = 130,
    parameter int QB   = 33
) (
    input  wire logic                    aclk,
    input  wire logic                    en,
    input  wire logic [NUMW-1:0]         num,
    input  wire logic [DENW-1:0]         den,
    input  wire logic                    neg,
    output logic      [W-1:0]            q_out,
    output logic                         sat_out
);
    import mi3_pkg::*;

    // Leading stage: operands and overflow precheck
    logic [NW-1:0]   num_p_reg;
    logic [DENW-1:0] den_p_reg;
    mi3_sgn_t        ctl_p_reg;

    // Quotient stages, one bit each
    logic [NW-1:0]   rem_reg  [QB];
    logic [NW-1:0]   rem_next [QB];
    logic [DENW-1:0] dv_reg   [QB];
    logic [QB-1:0]   q_reg    [QB];
    logic [QB-1:0]   q_next   [QB];
    mi3_sgn_t        ctl_reg  [QB];

    logic [NW-1:0]   num_ext;
    logic            ovf_next;
    logic [QB-1:0]   lim;
    logic [QB-1:0]   q_sel;
    logic            sat_next;
    logic [W-1:0]    q_out_next;

    // Flag quotients too wide for QB bits
    always_comb begin
        num_ext  = NW'(num);
        ovf_next = num_ext >= (NW'(den) << QB);
    end

    // Trial subtract at each stage
    always_comb begin
        logic [NW-1:0] src_rem;
        logic [NW-1:0] dsh;
        logic [QB-1:0] src_q;
        for (int s = 0; s < QB; s++) begin
            src_rem = (s == 0) ? num_p_reg : rem_reg[(s == 0) ? 0 : s-1];
            src_q   = (s == 0) ? '0 : q_reg[(s == 0) ? 0 : s-1];
            dsh     = (s == 0) ? (NW'(den_p_reg) << (QB-1))
                               : (NW'(dv_reg[(s == 0) ? 0 : s-1]) << (QB-1-s));
            rem_next[s] = src_rem;
            q_next[s]   = src_q;
            if (src_rem >= dsh) begin
                rem_next[s] = src_rem - dsh;
                q_next[s]   = src_q | (QB'(1) << (QB-1-s));
            end
        end
    end

    // Clip to the signed range and apply the sign
    always_comb begin
        lim = ctl_reg[QB-1].neg ? (QB'(1) << (W-1)) : ((QB'(1) << (W-1)) - QB'(1));
        q_sel    = q_reg[QB-1];
        sat_next = 1'b0;
        if (ctl_reg[QB-1].ovf || (q_reg[QB-1] > lim)) begin
            q_sel    = lim;
            sat_next = 1'b1;
        end
        q_out_next = ctl_reg[QB-1].neg ? W'(-q_sel) : W'(q_sel);
    end

    // Advance all stages together
    always_ff @(posedge aclk) begin
        if (en) begin
            num_p_reg     <= num_ext;
            den_p_reg     <= den;
            ctl_p_reg.neg <= neg;
            ctl_p_reg.ovf <= ovf_next;
            for (int s = 0; s < QB; s++) begin
                rem_reg[s] <= rem_next[s];
                q_reg[s]   <= q_next[s];
                dv_reg[s]  <= (s == 0) ? den_p_reg : dv_reg[(s == 0) ? 0 : s-1];
                ctl_reg[s] <= (s == 0) ? ctl_p_reg : ctl_reg[(s == 0) ? 0 : s-1];
            end
            q_out   <= q_out_next;
            sat_out <= sat_next;
        end
    end

endmodule

`default_nettype wire

### design/matrix_inverse_3x3_core.sv
// Top level of the 3x3 matrix inverse core (adjugate over determinant).
// Depends on mi3_pkg and mi3_div_lane.
`default_nettype none

// Streams one signed fixed-point 3x3 matrix per cycle and returns its inverse,
// rounded to nearest with ties away from zero and saturated to the word range.
// A new matrix is taken in every cycle while the output side keeps up; the
// default format is Q16.16, and each of the nine divider lanes retires one
// quotient bit per stage. A stall on m_tready while a result waits holds the
// whole pipeline in place. Determinants whose magnitude is below min_det (in
// the fraction format) are replaced by +min_det and flagged in tuser. min_det
// is written on the cfg channel at any time the core is idle.
module matrix_inverse_3x3_core #(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = mi3_pkg::WORD_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    // Input matrix, lowest bits up: m00 m01 m02 m10 m11 m12 m20 m21 m22
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [((9*WORD_BITS+7)/8)*8-1:0]     s_tdata,
    // Inverse, lowest bits up: r00 r01 r02 r10 r11 r12 r20 r21 r22
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic      [((9*WORD_BITS+7)/8)*8-1:0]     m_tdata,
    // Flags, lowest bit up: near_singular saturated
    output logic      [1:0]                           m_tuser,
    // Determinant floor register
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [mi3_pkg::MIN_DET_BITS-1:0]     cfg_data
);
    import mi3_pkg::*;

    localparam int W     = WORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int TDW   = ((9*W+7)/8)*8;
    localparam int PW    = 2*W;
    localparam int CW    = 2*W+1;
    localparam int CMW   = 2*W;
    localparam int HPW   = 2*W+1;
    localparam int DETW  = 3*W+1;
    localparam int ADW   = (3*W > MIN_DET_BITS+2*F) ? 3*W : MIN_DET_BITS+2*F;
    localparam int DENW  = ADW+1;
    localparam int NUMA  = (2*W+2*F+1 > ADW) ? 2*W+2*F+1 : ADW;
    localparam int NUMW  = NUMA+1;
    localparam int QB    = W+1;
    localparam int NW    = (NUMW > DENW+QB) ? NUMW : DENW+QB;
    localparam int LL    = QB+2;
    localparam int NV    = 7+LL;
    localparam int PA [3] = '{1, 2, 0};
    localparam int PB [3] = '{2, 0, 1};

    logic en;
    logic [MIN_DET_BITS-1:0] min_det_reg;
    logic [NV-1:0]           vld_reg;

    logic signed [W-1:0]    m_reg    [9];
    logic signed [PW-1:0]   prod_reg [9][2];
    logic signed [CW-1:0]   cof_reg  [9];
    logic signed [W-1:0]    r0_reg   [3];
    logic signed [W-1:0]    r0b_reg  [3];
    logic signed [HPW-1:0]  pl_reg   [3];
    logic signed [HPW-1:0]  ph_reg   [3];
    logic signed [CW-1:0]   cof4_reg [9];
    logic signed [DETW-1:0] det_reg;
    logic signed [CW-1:0]   cof5_reg [9];
    logic [ADW-1:0]         adf_reg;
    logic                   dneg_reg;
    logic                   ns6_reg;
    logic [CMW-1:0]         cmag_reg [9];
    logic                   csgn_reg [9];
    logic [NUMW-1:0]        num_reg  [9];
    logic [DENW-1:0]        den_reg;
    logic                   neg_reg  [9];
    logic                   ns7_reg;
    logic [LL-1:0]          ns_dly_reg;

    logic signed [PW-1:0]   prod_next [9][2];
    logic signed [HPW-1:0]  pl_next   [3];
    logic signed [HPW-1:0]  ph_next   [3];
    logic signed [DETW-1:0] det_next;
    logic [MIN_DET_BITS-1:0] fv;
    logic [ADW-1:0]         fl;
    logic [ADW-1:0]         ad;
    logic [DETW-1:0]        dabs;
    logic                   ns_next;
    logic [W-1:0]           q_lane   [9];
    logic                   sat_lane [9];
    logic                   sat_any;

    // Hold the pipeline while a result waits
    assign en        = !vld_reg[NV-1] || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // Floor register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_det_reg <= MIN_DET_BITS'(1);
        end else if (cfg_valid) begin
            min_det_reg <= cfg_data;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NV-2:0], s_tvalid};
        end
    end

    // Cross-product terms of each row pair
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod_next[i*3+0][0] = PW'(m_reg[PA[i]*3+1]) * PW'(m_reg[PB[i]*3+2]);
            prod_next[i*3+0][1] = PW'(m_reg[PA[i]*3+2]) * PW'(m_reg[PB[i]*3+1]);
            prod_next[i*3+1][0] = PW'(m_reg[PA[i]*3+2]) * PW'(m_reg[PB[i]*3+0]);
            prod_next[i*3+1][1] = PW'(m_reg[PA[i]*3+0]) * PW'(m_reg[PB[i]*3+2]);
            prod_next[i*3+2][0] = PW'(m_reg[PA[i]*3+0]) * PW'(m_reg[PB[i]*3+1]);
            prod_next[i*3+2][1] = PW'(m_reg[PA[i]*3+1]) * PW'(m_reg[PB[i]*3+0]);
        end
    end

    // Determinant partial products, cofactor split into low and high halves
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            pl_next[j] = HPW'(r0b_reg[j]) * HPW'($signed({1'b0, cof_reg[j][W-1:0]}));
            ph_next[j] = HPW'(r0b_reg[j]) * HPW'($signed(cof_reg[j][CW-1:W]));
        end
    end

    // Sum the partial products into the determinant
    always_comb begin
        det_next = '0;
        for (int j = 0; j < 3; j++) begin
            det_next = det_next + (DETW'(ph_reg[j]) <<< W) + DETW'(pl_reg[j]);
        end
    end

    // Magnitude and floor
    always_comb begin
        fv      = (min_det_reg == '0) ? MIN_DET_BITS'(1) : min_det_reg;
        fl      = ADW'(fv) << (2*F);
        dabs    = det_reg[DETW-1] ? DETW'(-det_reg) : DETW'(det_reg);
        ad      = ADW'(dabs);
        ns_next = ad < fl;
    end

    // Datapath stages
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                m_reg[k] <= s_tdata[k*W +: W];
            end
            prod_reg <= prod_next;
            for (int k = 0; k < 9; k++) begin
                cof_reg[k] <= CW'(prod_reg[k][0]) - CW'(prod_reg[k][1]);
            end
            for (int j = 0; j < 3; j++) begin
                r0_reg[j]  <= m_reg[j];
                r0b_reg[j] <= r0_reg[j];
            end
            pl_reg   <= pl_next;
            ph_reg   <= ph_next;
            cof4_reg <= cof_reg;
            det_reg  <= det_next;
            cof5_reg <= cof4_reg;
            adf_reg  <= ns_next ? fl : ad;
            dneg_reg <= !ns_next && det_reg[DETW-1];
            ns6_reg  <= ns_next;
            for (int k = 0; k < 9; k++) begin
                cmag_reg[k] <= cof5_reg[k][CW-1] ? CMW'(-cof5_reg[k]) : CMW'(cof5_reg[k]);
                csgn_reg[k] <= cof5_reg[k][CW-1];
            end
            for (int k = 0; k < 9; k++) begin
                num_reg[k] <= (NUMW'(cmag_reg[k]) << (2*F+1)) + NUMW'(adf_reg);
                neg_reg[k] <= csgn_reg[k] ^ dneg_reg;
            end
            den_reg    <= DENW'(adf_reg) << 1;
            ns7_reg    <= ns6_reg;
            ns_dly_reg <= {ns_dly_reg[LL-2:0], ns7_reg};
        end
    end

    // Nine divider lanes; entry (i,j) divides cofactor (j,i)
    for (genvar i = 0; i < 3; i++) begin : g_row
        for (genvar j = 0; j < 3; j++) begin : g_col
            mi3_div_lane #(
                .W    (W),
                .NUMW (NUMW),
                .DENW (DENW),
                .NW   (NW),
                .QB   (QB)
            ) u_lane (
                .aclk    (aclk),
                .en      (en),
                .num     (num_reg[j*3+i]),
                .den     (den_reg),
                .neg     (neg_reg[j*3+i]),
                .q_out   (q_lane[i*3+j]),
                .sat_out (sat_lane[i*3+j])
            );
        end
    end

    // Pack the result transaction
    always_comb begin
        m_tdata = '0;
        sat_any = 1'b0;
        for (int k = 0; k < 9; k++) begin
            m_tdata[k*W +: W] = q_lane[k];
            sat_any           = sat_any | sat_lane[k];
        end
    end

    assign m_tvalid = vld_reg[NV-1];
    assign m_tuser  = {sat_any, ns_dly_reg[LL-1]};

endmodule

`default_nettype wire

### tb/matrix_inverse_3x3_core_test.sv
// Self-checking testbench for matrix_inverse_3x3_core: streams matrices, predicts each
// inverse with exact wide arithmetic and compares every result word and flag.
// Depends on mi3_pkg and the core RTL only.
`timescale 1ns / 100ps

module matrix_inverse_3x3_core_test;
    import mi3_pkg::*;

    localparam int WB = WORD_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int DW = ((9*WB+7)/8)*8;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [DW-1:0] words;
        logic [1:0]    flags;   // near_singular, saturated from bit 0 up
    } inverse_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [DW-1:0] m_tdata;
    logic [1:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [MIN_DET_BITS-1:0] cfg_data = '0;

    logic [DW-1:0] matrix_q[$];
    inverse_t inverse_q[$];
    logic [MIN_DET_BITS-1:0] det_floor = MIN_DET_BITS'(1);
    bit quiet = 0;
    int errors = 0;
    int cycles = 0;
    int accepted = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_left = 0;
    bit hold_done = 0;

    matrix_inverse_3x3_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // Exact adjugate inverse with round-half-away and saturation
    function automatic inverse_t invert_matrix(input logic [DW-1:0] d,
                                               input logic [MIN_DET_BITS-1:0] fl_v);
        logic signed [191:0] m[3][3];
        logic signed [191:0] cof[3][3];
        logic signed [191:0] det, c;
        logic [191:0] ad, fl, num, den, q, lim, ac;
        int a_row[3];
        int b_row[3];
        bit dneg, neg, ns, sat;
        inverse_t r;
        a_row = '{1, 2, 0};
        b_row = '{2, 0, 1};
        ns = 0;
        sat = 0;
        r = '0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = $signed(d[(i*3+j)*WB +: WB]);
        for (int i = 0; i < 3; i++) begin
            cof[i][0] = m[a_row[i]][1]*m[b_row[i]][2] - m[a_row[i]][2]*m[b_row[i]][1];
            cof[i][1] = m[a_row[i]][2]*m[b_row[i]][0] - m[a_row[i]][0]*m[b_row[i]][2];
            cof[i][2] = m[a_row[i]][0]*m[b_row[i]][1] - m[a_row[i]][1]*m[b_row[i]][0];
        end
        det = m[0][0]*cof[0][0] + m[0][1]*cof[0][1] + m[0][2]*cof[0][2];
        fl = {161'b0, (fl_v == 0) ? 31'd1 : fl_v} << (2*FB);
        ad = (det < 0) ? -det : det;
        dneg = det < 0;
        // Replace a too-small determinant by the positive floor
        if (ad < fl) begin
            ad = fl;
            dneg = 0;
            ns = 1;
        end
        den = ad << 1;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                c = cof[j][i];
                neg = (c < 0) ^ dneg;
                ac = (c < 0) ? -c : c;
                num = (ac << (2*FB+1)) + ad;
                q = num / den;
                lim = neg ? (192'd1 << (WB-1)) : ((192'd1 << (WB-1)) - 1);
                if (q > lim) begin
                    q = lim;
                    sat = 1;
                end
                r.words[(i*3+j)*WB +: WB] = neg ? -q[WB-1:0] : q[WB-1:0];
            end
        r.flags = {sat, ns};
        return r;
    endfunction

    // Random entry: full range, small well-scaled values, tiny values, or mid-range values
    function automatic logic [WB-1:0] rand_entry(input int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            2: return $urandom_range(0, 64) - 32;
            default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        endcase
    endfunction

    function automatic logic [DW-1:0] rand_matrix();
        logic [DW-1:0] d;
        int mode;
        mode = $urandom_range(0, 5);
        d = '0;
        for (int k = 0; k < 9; k++)
            d[k*WB +: WB] = rand_entry(mode > 3 ? 1 : mode);
        // Strengthen the diagonal now and then for well-conditioned inverses
        if (mode == 5)
            for (int k = 0; k < 3; k++)
                d[(k*4)*WB +: WB] = d[(k*4)*WB +: WB] + 32'h0010_0000;
        return d;
    endfunction

    function automatic logic [DW-1:0] fill_matrix(input logic [WB-1:0] v0,
                                                  input logic [WB-1:0] v1);
        logic [DW-1:0] d;
        for (int k = 0; k < 9; k++)
            d[k*WB +: WB] = (k % 4 == 0) ? v0 : v1;
        return d;
    endfunction

    // Sender: hold until accepted, then advance from the queue or idle a burst
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                inverse_q.push_back(invert_matrix(s_tdata, det_floor));
                accepted <= accepted + 1;
            end
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (matrix_q.size() != 0 && !quiet && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(0, 8);
                s_tvalid <= 1'b0;
            end else if (matrix_q.size() != 0) begin
                s_tdata <= matrix_q.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off to back up the pipeline
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (!hold_done && accepted >= 300) begin
            hold_done <= 1;
            hold_left <= 250;
            m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(0, 8);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        inverse_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (inverse_q.size() == 0) begin
                $display("%0t: unexpected result tdata=%h tuser=%b", $time, m_tdata, m_tuser);
                errors++;
            end else begin
                want = inverse_q.pop_front();
                for (int k = 0; k < 9; k++)
                    if (want.words[k*WB +: WB] !== m_tdata[k*WB +: WB]) begin
                        $display("%0t: r%0d%0d expected %h actual %h", $time, k/3, k%3,
                                 want.words[k*WB +: WB], m_tdata[k*WB +: WB]);
                        errors++;
                    end
                if (want.flags[0] !== m_tuser[0]) begin
                    $display("%0t: near_singular expected %b actual %b", $time,
                             want.flags[0], m_tuser[0]);
                    errors++;
                end
                if (want.flags[1] !== m_tuser[1]) begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             want.flags[1], m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_floor(input logic [MIN_DET_BITS-1:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        det_floor = v;
    endtask

    task automatic drain();
        while (matrix_q.size() != 0 || s_tvalid || inverse_q.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic queue_random(input int n);
        repeat (n) matrix_q.push_back(rand_matrix());
    endtask

    initial begin
        logic [DW-1:0] d;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: identity, zero, extremes, sign cases, tiny and huge determinants
        matrix_q.push_back(fill_matrix(32'h0001_0000, 32'h0));
        matrix_q.push_back(fill_matrix(32'h0, 32'h0));
        matrix_q.push_back(fill_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF));
        matrix_q.push_back(fill_matrix(32'h8000_0000, 32'h8000_0000));
        matrix_q.push_back(fill_matrix(32'h8000_0000, 32'h0));
        matrix_q.push_back(fill_matrix(32'h7FFF_FFFF, 32'h0));
        matrix_q.push_back(fill_matrix(32'hFFFF_FFFF, 32'h0));
        matrix_q.push_back(fill_matrix(32'h0000_0001, 32'h0));
        matrix_q.push_back(fill_matrix(32'hFFFF_0000, 32'h0));
        matrix_q.push_back(fill_matrix(32'h0002_0000, 32'h0000_8000));
        matrix_q.push_back(fill_matrix(32'h8000_0000, 32'h7FFF_FFFF));
        matrix_q.push_back(fill_matrix(32'h0100_0000, 32'hFFFF_FFFF));
        d = fill_matrix(32'h0001_0000, 32'h0);
        d[0 +: WB] = 32'hFFFF_0000;        // negative determinant
        matrix_q.push_back(d);
        d = fill_matrix(32'h0003_0000, 32'h0);
        d[WB +: WB] = 32'h0001_0000;       // rounding of thirds
        matrix_q.push_back(d);
        d = fill_matrix(32'h0000_0100, 32'h0000_0080);
        matrix_q.push_back(d);
        for (int k = 0; k < 9; k++)
            d[k*WB +: WB] = 32'h5555_5555 ^ {32{k[0]}};
        matrix_q.push_back(d);
        queue_random(600);
        drain();

        write_floor(31'h0001_0000);
        matrix_q.push_back(fill_matrix(32'h0001_0000, 32'h0));
        matrix_q.push_back(fill_matrix(32'h0000_8000, 32'h0));
        queue_random(500);
        drain();

        write_floor(31'h7FFF_FFFF);
        matrix_q.push_back(fill_matrix(32'h7FFF_FFFF, 32'h0));
        queue_random(300);
        drain();

        write_floor(31'h0);
        matrix_q.push_back(fill_matrix(32'h0, 32'h0));
        queue_random(300);
        drain();

        // Final stretch with no idling on either side
        write_floor(MIN_DET_BITS'($urandom_range(1, 32'h0010_0000)));
        quiet = 1;
        queue_random(300);
        drain();

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

### sim.f
design/mi3_pkg.sv
design/mi3_div_lane.sv
design/matrix_inverse_3x3_core.sv
tb/matrix_inverse_3x3_core_test.sv
